// File: hw/rtl/maf_pkg.sv
// Shared constants, types and state codes of the moving average filter.
package maf_pkg;

  localparam int WINDOW_MAX   = 256;
  localparam int SAMPLE_WIDTH = 32;
  localparam int DATA_W       = 32;
  localparam int AVG_W        = 32;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;
  localparam int POS_W        = $clog2(WINDOW_MAX);
  localparam int LEN_W        = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W        = SAMPLE_WIDTH + POS_W;
  localparam int CNT_W        = $clog2(SUM_W + 1);

  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_START,
    ST_DIVIDE,
    ST_HOLD
  } maf_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [LEN_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/maf_divider.sv
// Radix-2 restoring divider: signed sum by unsigned window length, truncated toward zero.
module maf_divider (
  input  logic              clk,
  input  logic              rst,
  input  maf_pkg::div_req_t req,
  output maf_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic                            neg;
  logic [maf_pkg::CNT_W-1:0]       count;
  logic [maf_pkg::LEN_W-1:0]       rem;
  logic [maf_pkg::LEN_W-1:0]       divisor;
  logic [maf_pkg::SUM_W-1:0]       quo;
  logic [maf_pkg::SUM_W-1:0]       magnitude;
  logic [maf_pkg::LEN_W:0]         trial;
  logic                            ge;

  assign magnitude = req.dividend[maf_pkg::SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign trial     = {rem, quo[maf_pkg::SUM_W-1]};
  assign ge        = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == maf_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= magnitude;
      rem     <= '0;
      divisor <= req.divisor;
      neg     <= req.dividend[maf_pkg::SUM_W-1];
      count   <= maf_pkg::CNT_W'(maf_pkg::SUM_W);
    end else if (busy) begin
      quo   <= {quo[maf_pkg::SUM_W-2:0], ge};
      rem   <= ge ? maf_pkg::LEN_W'(trial - {1'b0, divisor}) : trial[maf_pkg::LEN_W-1:0];
      count <= count - 1'b1;
    end
  end

  assign rsp = '{done: done, quotient: (neg ? $signed(~quo + 1'b1) : $signed(quo))};

endmodule

// File: hw/rtl/moving_average_filter_unit.sv
// Boxcar moving average filter: sample ring in RAM, running sum, iterative divide.
// An accepted sample passes read, update, sum, start, 40 divide steps and load to the output register;
// no new sample is taken until that average is loaded, and a stalled output holds the load back.
// The output register lets a finished average wait while the next sample is taken.
// Reset (synchronous) and any window_length write clear the ring through per-entry
// valid bits, the running sum and the write position; window_length resets to 256.
module moving_average_filter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [maf_pkg::APB_AW-1:0]   paddr,
  input  logic [maf_pkg::APB_DW-1:0]   pwdata,
  output logic [maf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [maf_pkg::DATA_W-1:0] sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [maf_pkg::AVG_W-1:0]  average
);

  maf_pkg::maf_state_t state, state_next;

  logic [maf_pkg::SAMPLE_WIDTH-1:0] mem [maf_pkg::WINDOW_MAX];
  logic [maf_pkg::SAMPLE_WIDTH-1:0] rdata;
  logic [maf_pkg::WINDOW_MAX-1:0]   live;

  logic [maf_pkg::LEN_W-1:0]        window_length;
  logic [maf_pkg::LEN_W-1:0]        len_next;
  logic [maf_pkg::POS_W-1:0]        pos;
  logic signed [maf_pkg::SUM_W-1:0] running_sum;
  logic signed [maf_pkg::SUM_W-1:0] delta;
  logic [maf_pkg::SAMPLE_WIDTH-1:0] cur;
  logic signed [maf_pkg::SUM_W-1:0] cur_ext;
  logic signed [maf_pkg::SUM_W-1:0] old_ext;
  logic [maf_pkg::LEN_W-1:0]        pos_inc;

  logic cfg_write;
  logic accept;
  logic out_take;
  logic do_update;
  logic do_sum;
  logic load_out;

  maf_pkg::div_req_t div_req;
  maf_pkg::div_rsp_t div_rsp;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && paddr[2] == maf_pkg::REG_WINDOW_LENGTH;
  assign prdata    = (paddr[2] == maf_pkg::REG_WINDOW_LENGTH)
                     ? maf_pkg::APB_DW'(window_length) : '0;

  always_comb begin
    len_next = pwdata[maf_pkg::LEN_W-1:0];
    if (len_next == '0) begin
      len_next = maf_pkg::LEN_W'(1);
    end else if (len_next > maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX)) begin
      len_next = maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX);
    end
  end

  assign in_stall = state != maf_pkg::ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= maf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    do_update        = 1'b0;
    do_sum           = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = running_sum;
    div_req.divisor  = window_length;
    case (state)
      maf_pkg::ST_IDLE: begin
        if (accept) state_next = maf_pkg::ST_READ;
      end
      maf_pkg::ST_READ: begin
        do_update  = 1'b1;
        state_next = maf_pkg::ST_SUM;
      end
      maf_pkg::ST_SUM: begin
        do_sum     = 1'b1;
        state_next = maf_pkg::ST_START;
      end
      maf_pkg::ST_START: begin
        div_req.start = 1'b1;
        state_next    = maf_pkg::ST_DIVIDE;
      end
      maf_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          if (!out_valid || out_take) begin
            load_out   = 1'b1;
            state_next = maf_pkg::ST_IDLE;
          end else begin
            state_next = maf_pkg::ST_HOLD;
          end
        end
      end
      maf_pkg::ST_HOLD: begin
        if (!out_valid || out_take) begin
          load_out   = 1'b1;
          state_next = maf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = maf_pkg::ST_IDLE;
      end
    endcase
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (do_update) begin
      mem[pos] <= cur;
    end
    rdata <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= sample[maf_pkg::SAMPLE_WIDTH-1:0];
    end
    if (do_update) begin
      delta <= cur_ext - old_ext;
    end
  end

  assign cur_ext = maf_pkg::SUM_W'($signed(cur));
  assign old_ext = live[pos] ? maf_pkg::SUM_W'($signed(rdata)) : '0;
  assign pos_inc = maf_pkg::LEN_W'(pos) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX);
      live          <= '0;
      pos           <= '0;
      running_sum   <= '0;
    end else if (cfg_write) begin
      window_length <= len_next;
      live          <= '0;
      pos           <= '0;
      running_sum   <= '0;
    end else begin
      if (do_update) begin
        live[pos] <= 1'b1;
        pos       <= (pos_inc >= window_length) ? '0 : pos_inc[maf_pkg::POS_W-1:0];
      end
      if (do_sum) begin
        running_sum <= running_sum + delta;
      end
    end
  end

  maf_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average <= maf_pkg::AVG_W'(div_rsp.quotient);
    end
  end

endmodule

// File: hw/rtl/maf_checker.sv
// Port-level checks of the moving average filter, bound to the top level.
module maf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [maf_pkg::AVG_W-1:0] average
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average))
    else $error("stalled average changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("average shown with no request in work");

endmodule

bind moving_average_filter_unit maf_checker u_maf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .average   (average)
);

// File: tb/moving_average_filter_unit_tb.sv
// Self-checking testbench for the boxcar moving average filter unit.
module moving_average_filter_unit_tb;

  localparam int LIMIT        = 1_000_000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_FROM   = 1750;
  localparam int DRAIN_CYCLES = 60;
  localparam int REG_UNUSED   = 1;

  class average_tracker;
    logic signed [maf_pkg::SAMPLE_WIDTH-1:0] ring [maf_pkg::WINDOW_MAX];
    int unsigned                             wpos;
    longint                                  acc;
    int unsigned                             win;
    logic signed [maf_pkg::AVG_W-1:0]        averages_due [$];
    int                                      mismatches;

    function new();
      win        = maf_pkg::WINDOW_MAX;
      mismatches = 0;
      clear_window();
    endfunction

    function void clear_window();
      for (int i = 0; i < maf_pkg::WINDOW_MAX; i++) ring[i] = '0;
      wpos = 0;
      acc  = 0;
    endfunction

    function void set_window(int index, logic [maf_pkg::APB_DW-1:0] value);
      int unsigned len;
      if (index != int'(maf_pkg::REG_WINDOW_LENGTH)) return;
      len = value & 32'h1FF;
      if (len == 0) len = 1;
      if (len > maf_pkg::WINDOW_MAX) len = maf_pkg::WINDOW_MAX;
      win = len;
      clear_window();
    endfunction

    function void take_sample(logic signed [maf_pkg::DATA_W-1:0] s);
      int unsigned idx;
      longint      quot;
      idx = wpos;
      if (idx >= win) idx = 0;
      acc = acc + longint'(s) - longint'(ring[idx]);
      ring[idx] = s;
      quot = acc / longint'(win);
      averages_due.push_back(quot[maf_pkg::AVG_W-1:0]);
      idx++;
      if (idx >= win) idx = 0;
      wpos = idx;
    endfunction

    function void match_average(logic signed [maf_pkg::AVG_W-1:0] got);
      logic signed [maf_pkg::AVG_W-1:0] want;
      if (averages_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected average %0d", got);
        return;
      end
      want = averages_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("average mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return averages_due.size();
    endfunction
  endclass

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               psel      = 1'b0;
  logic                               penable   = 1'b0;
  logic                               pwrite    = 1'b0;
  logic [maf_pkg::APB_AW-1:0]         paddr     = '0;
  logic [maf_pkg::APB_DW-1:0]         pwdata    = '0;
  logic [maf_pkg::APB_DW-1:0]         prdata;
  logic                               pready;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  logic signed [maf_pkg::DATA_W-1:0]  sample    = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [maf_pkg::AVG_W-1:0]   average;

  logic                               quiet = 1'b0;
  int                                 stall_left = 0;
  int                                 cycles = 0;
  average_tracker                     tracker = new();

  moving_average_filter_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .average(average)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("moving_average_filter_unit_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.match_average(average);
      if (in_valid && !in_stall) tracker.take_sample(sample);
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_sample(logic [maf_pkg::DATA_W-1:0] v);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(int index, logic [maf_pkg::APB_DW-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= maf_pkg::APB_AW'(index * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_window(index, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [maf_pkg::DATA_W-1:0] rand_sample();
    logic [maf_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2, 3:    v = $urandom;
      4, 5:    v = 32'($urandom_range(0, 2000)) - 32'd1000;
      6:       v = {1'b1, 31'($urandom)};
      default: v = 32'($urandom_range(0, 7)) ^ {32{1'($urandom_range(0, 1))}};
    endcase
    return v;
  endfunction

  function automatic logic [maf_pkg::APB_DW-1:0] rand_window();
    logic [maf_pkg::APB_DW-1:0] v;
    case ($urandom_range(0, 7))
      0, 1:    v = $urandom_range(1, 8);
      2:       v = maf_pkg::WINDOW_MAX;
      3:       v = $urandom_range(257, 511);
      4:       v = 0;
      default: v = $urandom_range(1, 256);
    endcase
    if ($urandom_range(0, 3) == 0) v = v | ($urandom & 32'hFFFF_FE00);
    return v;
  endfunction

  initial begin
    int sent;
    int n;
    int reg_index;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window of 256 straight out of reset
    send_sample(32'h0000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    write_reg(int'(maf_pkg::REG_WINDOW_LENGTH), 1);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    // zero length is taken as one
    write_reg(int'(maf_pkg::REG_WINDOW_LENGTH), 0);
    send_sample(32'd5);
    write_reg(int'(maf_pkg::REG_WINDOW_LENGTH), 2);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFD);
    send_sample(32'h0000_0000);
    // unmapped register: window stays at two
    write_reg(REG_UNUSED, 3);
    send_sample(32'd1);
    send_sample(32'd2);
    send_sample(32'd3);
    // oversize lengths saturate
    write_reg(int'(maf_pkg::REG_WINDOW_LENGTH), 300);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    write_reg(int'(maf_pkg::REG_WINDOW_LENGTH), 32'h3FF);
    send_sample(32'd7);

    while (sent < RANDOM_ITEMS) begin
      reg_index = ($urandom_range(0, 11) == 0) ? REG_UNUSED
                                                : int'(maf_pkg::REG_WINDOW_LENGTH);
      write_reg(reg_index, rand_window());
      if (tracker.win >= 128) n = $urandom_range(tracker.win + 10, tracker.win + 80);
      else n = $urandom_range(3 * tracker.win + 4, 3 * tracker.win + 60);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      for (int i = 0; i < n; i++) begin
        send_sample(rand_sample());
        sent++;
        if (sent == QUIET_FROM) quiet <= 1'b1;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("moving_average_filter_unit_tb: clean");
    end else begin
      $display("moving_average_filter_unit_tb: errors");
    end
    $finish;
  end

endmodule
